// ===== design/pfx_pkg.sv =====
package pfx_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;

    localparam logic [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_OTHER
    } op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic push_digit;
        logic pop;
        logic cap_x;
        logic cap_y;
        logic exec;
        logic div_start;
        logic push_quot;
        logic emit;
    } pfx_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic last;
        logic x_zero;
        logic div_busy;
        logic out_free;
    } pfx_status_t;

    function automatic op_t classify(input logic [SYM_W-1:0] sym);
        op_t op;
        begin
            if (sym inside {[CHAR_ZERO:CHAR_NINE]})
            begin
                op = OP_DIGIT;
            end
            else
            begin
                case (sym)
                    CHAR_PLUS:  op = OP_ADD;
                    CHAR_MINUS: op = OP_SUB;
                    CHAR_STAR:  op = OP_MUL;
                    CHAR_SLASH: op = OP_DIV;
                    default:    op = OP_OTHER;
                endcase
            end
            return op;
        end
    endfunction

endpackage

// ===== design/pfx_in_if.sv =====
interface pfx_in_if;
    logic                     valid;
    logic                     ready;
    logic [pfx_pkg::SYM_W-1:0] symbol;
    logic                     last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

// ===== design/pfx_out_if.sv =====
interface pfx_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [pfx_pkg::DATA_W-1:0] value;
    logic                             underflow_seen;
    logic                             overflow_seen;
    logic                             divide_by_zero_seen;

    modport source (
        output valid, output value, output underflow_seen,
        output overflow_seen, output divide_by_zero_seen, input ready
    );
    modport sink (
        input valid, input value, input underflow_seen,
        input overflow_seen, input divide_by_zero_seen, output ready
    );
endinterface

// ===== design/pfx_divider.sv =====
module pfx_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pfx_pkg::DATA_W-1:0]  dividend,
    input  logic [pfx_pkg::DATA_W-1:0]  divisor,
    output logic                        busy,
    output logic [pfx_pkg::DATA_W-1:0]  quotient
);

    localparam int W = pfx_pkg::DATA_W;

    logic [W-1:0]                  quo_reg, quo_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  den_reg, den_next;
    logic                          neg_reg, neg_next;
    logic [pfx_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [W-1:0] mag_n;
    logic [W-1:0] mag_d;
    logic [W:0]   rem_shift;
    logic [W:0]   diff;

    // magnitudes; the most negative value maps to its own unsigned magnitude
    assign mag_n = dividend[W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_d = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;

    // restoring step, one quotient bit a cycle
    // the remainder stays below the divisor, so it always fits in W bits
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    assign busy     = (cnt_reg != '0);
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = mag_n;
            rem_next = '0;
            den_next = mag_d;
            neg_next = dividend[W-1] ^ divisor[W-1];
            cnt_next = pfx_pkg::DIV_CNT_W'(pfx_pkg::DIV_STEPS);
        end
        else if (busy)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("divider not busy after start");

    a_count_down : assert property (@(posedge clk) disable iff (!rst_n)
        busy && !start |=> cnt_reg == pfx_pkg::DIV_CNT_W'($past(cnt_reg) - 1'b1))
        else $error("divider step count skipped");

endmodule

// ===== design/pfx_datapath.sv =====
module pfx_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pfx_pkg::pfx_cmd_t                  cmd,
    output pfx_pkg::pfx_status_t               status,
    input  logic [pfx_pkg::SYM_W-1:0]          symbol,
    input  logic                               last_symbol,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic signed [pfx_pkg::DATA_W-1:0]  value,
    output logic                               underflow_seen,
    output logic                               overflow_seen,
    output logic                               divide_by_zero_seen
);

    localparam int W = pfx_pkg::DATA_W;

    logic [W-1:0] stack_mem [pfx_pkg::STACK_DEPTH];

    logic [pfx_pkg::SYM_W-1:0] sym_reg;
    logic                      last_reg;
    logic [pfx_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      underflow_reg, underflow_next;
    logic                      overflow_reg, overflow_next;
    logic                      div_zero_reg, div_zero_next;
    logic                      pop_empty_reg;
    logic [W-1:0]              rd_data_reg;
    logic [W-1:0]              x_reg;
    logic [W-1:0]              y_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [W-1:0]              out_value_reg;
    logic                      out_uf_reg;
    logic                      out_of_reg;
    logic                      out_dz_reg;

    pfx_pkg::op_t              op;
    logic                      pop_ok;
    logic                      push_ok;
    logic                      push_req;
    logic [pfx_pkg::CNT_W-1:0] count_dec;
    logic [pfx_pkg::IDX_W-1:0] rd_idx;
    logic [pfx_pkg::IDX_W-1:0] wr_idx;
    logic [W-1:0]              popped;
    logic [W-1:0]              digit_val;
    logic [W-1:0]              alu_res;
    logic [W-1:0]              push_data;
    logic [W-1:0]              div_quot;
    logic                      div_busy;

    pfx_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (y_reg),
        .divisor  (x_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign op        = pfx_pkg::classify(sym_reg);
    assign pop_ok    = (count_reg != '0);
    assign push_ok   = (count_reg != pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH));
    assign count_dec = count_reg - 1'b1;
    assign rd_idx    = count_dec[pfx_pkg::IDX_W-1:0];
    assign wr_idx    = count_reg[pfx_pkg::IDX_W-1:0];
    assign popped    = pop_empty_reg ? pfx_pkg::MOST_NEGATIVE : rd_data_reg;
    assign digit_val = {{(W-pfx_pkg::SYM_W){1'b0}}, sym_reg - pfx_pkg::CHAR_ZERO};
    assign push_req  = cmd.push_digit | cmd.exec | cmd.push_quot;

    always_comb
    begin
        case (op)
            pfx_pkg::OP_ADD: alu_res = y_reg + x_reg;
            pfx_pkg::OP_SUB: alu_res = y_reg - x_reg;
            pfx_pkg::OP_MUL: alu_res = y_reg * x_reg;
            default:         alu_res = '0;   // division by zero pushes zero
        endcase
    end

    always_comb
    begin
        if (cmd.push_digit)
        begin
            push_data = digit_val;
        end
        else if (cmd.push_quot)
        begin
            push_data = div_quot;
        end
        else
        begin
            push_data = alu_res;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        underflow_next = underflow_reg;
        overflow_next  = overflow_reg;
        div_zero_next  = div_zero_reg;
        out_valid_next = out_valid_reg && !res_ready;
        if (cmd.pop)
        begin
            if (pop_ok)
            begin
                count_next = count_dec;
            end
            else
            begin
                underflow_next = 1'b1;
            end
        end
        if (push_req)
        begin
            if (push_ok)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        if (cmd.exec && op == pfx_pkg::OP_DIV)
        begin
            div_zero_next = 1'b1;
        end
        if (cmd.emit)
        begin
            count_next     = '0;
            underflow_next = 1'b0;
            overflow_next  = 1'b0;
            div_zero_next  = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            underflow_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            div_zero_reg  <= 1'b0;
            pop_empty_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            underflow_reg <= underflow_next;
            overflow_reg  <= overflow_next;
            div_zero_reg  <= div_zero_next;
            out_valid_reg <= out_valid_next;
            if (cmd.pop)
            begin
                pop_empty_reg <= !pop_ok;
            end
        end
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_req && push_ok)
        begin
            stack_mem[wr_idx] <= push_data;
        end
        if (cmd.pop && pop_ok)
        begin
            rd_data_reg <= stack_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sym_reg  <= symbol;
            last_reg <= last_symbol;
        end
        if (cmd.cap_x)
        begin
            x_reg <= popped;
        end
        if (cmd.cap_y)
        begin
            y_reg <= popped;
        end
        if (cmd.emit)
        begin
            out_value_reg <= popped;
            out_uf_reg    <= underflow_reg;
            out_of_reg    <= overflow_reg;
            out_dz_reg    <= div_zero_reg;
        end
    end

    assign status.op       = op;
    assign status.last     = last_reg;
    assign status.x_zero   = (x_reg == '0);
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || res_ready;

    assign res_valid           = out_valid_reg;
    assign value               = out_value_reg;
    assign underflow_seen      = out_uf_reg;
    assign overflow_seen       = out_of_reg;
    assign divide_by_zero_seen = out_dz_reg;

    a_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        push_req && !push_ok && !cmd.emit |=> overflow_reg && $stable(count_reg))
        else $error("push onto full stack not dropped");

    a_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop && !pop_ok |=> underflow_reg && pop_empty_reg)
        else $error("pop from empty stack not flagged");

    a_emit_clear : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> count_reg == '0 && !underflow_reg && !overflow_reg
                     && !div_zero_reg && out_valid_reg)
        else $error("expression state not cleared on emit");

endmodule

// ===== design/pfx_ctrl.sv =====
module pfx_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sym_valid,
    output logic                  sym_ready,
    input  pfx_pkg::pfx_status_t  status,
    output pfx_pkg::pfx_cmd_t     cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_POP_Y  = 8'b0000_0100,
        S_CAP_Y  = 8'b0000_1000,
        S_EXEC   = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_LAST   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign sym_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (sym_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.op == pfx_pkg::OP_DIGIT)
                begin
                    cmd.push_digit = 1'b1;
                    state_next     = S_LAST;
                end
                else
                begin
                    cmd.pop    = 1'b1;   // x
                    state_next = S_POP_Y;
                end
            end
            S_POP_Y:
            begin
                cmd.cap_x  = 1'b1;
                cmd.pop    = 1'b1;       // y
                state_next = S_CAP_Y;
            end
            S_CAP_Y:
            begin
                cmd.cap_y  = 1'b1;
                state_next = (status.op == pfx_pkg::OP_OTHER) ? S_LAST : S_EXEC;
            end
            S_EXEC:
            begin
                if (status.op == pfx_pkg::OP_DIV && !status.x_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_LAST;
                end
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.push_quot = 1'b1;
                    state_next    = S_LAST;
                end
            end
            S_LAST:
            begin
                if (status.last)
                begin
                    cmd.pop    = 1'b1;   // final value
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/postfix_expression_evaluator.sv =====
// Postfix (reverse Polish) expression evaluator, one ASCII character per transfer on
// sym_ch, with last_symbol marking the final character. Digits push 0..9, + - * / pop
// two operands and push the 32-bit wrapping result (division truncates toward zero,
// a zero divisor pushes 0 and sets divide_by_zero_seen), any other character pops two
// and pushes nothing. Popping an empty stack gives the most negative value and sets
// underflow_seen; a push onto the full 32-entry stack is dropped and sets
// overflow_seen. After the final character the top is popped and sent on res_ch with
// the three flags, and the stack and flags clear. One character is processed at a time;
// a division is the slowest (its 32-step shift-subtract divider sets the worst case),
// and a final character adds the S_EMIT state after the last pop. A finished result sits
// in an output register, so the next expression starts while it waits; only a second final
// character stalls until res_ch is free.
module postfix_expression_evaluator (
    input  logic              clk,
    input  logic              rst_n,
    pfx_in_if.sink            sym_ch,
    pfx_out_if.source         res_ch
);

    // command and status bundles between sequencer and datapath
    pfx_pkg::pfx_cmd_t    cmd;
    pfx_pkg::pfx_status_t status;

    // sequencer: walks pop/pop/execute/push for each operator, push for a digit, pop/pop for others
    pfx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_ch.valid),
        .sym_ready (sym_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: operand stack memory, alu, divider and result register
    pfx_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .symbol              (sym_ch.symbol),
        .last_symbol         (sym_ch.last_symbol),
        .res_valid           (res_ch.valid),
        .res_ready           (res_ch.ready),
        .value               (res_ch.value),
        .underflow_seen      (res_ch.underflow_seen),
        .overflow_seen       (res_ch.overflow_seen),
        .divide_by_zero_seen (res_ch.divide_by_zero_seen)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // one character as offered on the symbol channel
    typedef struct packed {
        logic [pfx_pkg::SYM_W-1:0] sym;
        logic                      last;
    } symbol_item_t;

    // one finished expression as it should leave the result channel
    typedef struct packed {
        logic [pfx_pkg::DATA_W-1:0] value;
        logic                       underflow;
        logic                       overflow;
        logic                       div_zero;
    } expr_result_t;

    // receiver hold-off long enough to fill the output register and stall the input
    localparam int HOLD_CYCLES = 300;
    // cycles without any transfer before the run is declared hung
    localparam int IDLE_LIMIT  = 2000;
    // quiet cycles after the last result, well past the slowest character
    localparam int TAIL_CYCLES = 100;

    logic clk;
    logic rst_n;

    pfx_in_if  sym_ch_if ();
    pfx_out_if res_ch_if ();

    postfix_expression_evaluator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sym_ch (sym_ch_if),
        .res_ch (res_ch_if)
    );

    // characters waiting to be offered, and results still owed by the block
    symbol_item_t pending_symbols[$];
    expr_result_t expected_results[$];
    symbol_item_t next_symbol;
    expr_result_t got_result;
    expr_result_t want_result;

    // own copy of the evaluator state
    logic [pfx_pkg::DATA_W-1:0] eval_stack [0:pfx_pkg::STACK_DEPTH-1];
    int                         eval_depth     = 0;
    logic                       eval_underflow = 1'b0;
    logic                       eval_overflow  = 1'b0;
    logic                       eval_div_zero  = 1'b0;

    // idling odds per phase, in percent
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // bumped by the stimulus to ask the receiver for one long hold-off
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int idle_cycles    = 0;
    int mismatch_count = 0;

    // clock, and the single reset at the start of the run
    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        fork
            forever #10 clk = ~clk;
        join_none
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // a push onto a full stack is lost and only leaves the overflow flag
    function automatic void eval_push(input logic [pfx_pkg::DATA_W-1:0] v);
        if (eval_depth >= pfx_pkg::STACK_DEPTH)
        begin
            eval_overflow = 1'b1;
        end
        else
        begin
            eval_stack[eval_depth] = v;
            eval_depth++;
        end
    endfunction

    // popping an empty stack gives the most negative value
    function automatic logic [pfx_pkg::DATA_W-1:0] eval_pop();
        if (eval_depth == 0)
        begin
            eval_underflow = 1'b1;
            return pfx_pkg::MOST_NEGATIVE;
        end
        eval_depth--;
        return eval_stack[eval_depth];
    endfunction

    // apply one accepted character; the final one queues the owed result
    task automatic evaluate_symbol(input logic [pfx_pkg::SYM_W-1:0] sym, input logic last);
        logic [pfx_pkg::DATA_W-1:0] x;
        logic [pfx_pkg::DATA_W-1:0] y;
        logic [pfx_pkg::DATA_W-1:0] mag_n;
        logic [pfx_pkg::DATA_W-1:0] mag_d;
        logic [pfx_pkg::DATA_W-1:0] quot;
        expr_result_t               res;
        if (sym >= pfx_pkg::CHAR_ZERO && sym <= pfx_pkg::CHAR_NINE)
        begin
            eval_push({{(pfx_pkg::DATA_W-pfx_pkg::SYM_W){1'b0}}, sym - pfx_pkg::CHAR_ZERO});
        end
        else
        begin
            // every non-digit pops twice, even one that pushes nothing
            x = eval_pop();
            y = eval_pop();
            case (sym)
                pfx_pkg::CHAR_PLUS:  eval_push(y + x);
                pfx_pkg::CHAR_MINUS: eval_push(y - x);
                pfx_pkg::CHAR_STAR:  eval_push(y * x);
                pfx_pkg::CHAR_SLASH:
                begin
                    if (x == '0)
                    begin
                        eval_div_zero = 1'b1;
                        eval_push('0);
                    end
                    else
                    begin
                        // magnitudes keep the most negative over minus one wrapping
                        mag_n = y[pfx_pkg::DATA_W-1] ? -y : y;
                        mag_d = x[pfx_pkg::DATA_W-1] ? -x : x;
                        quot  = mag_n / mag_d;
                        eval_push((y[pfx_pkg::DATA_W-1] ^ x[pfx_pkg::DATA_W-1]) ? -quot
                                                                                : quot);
                    end
                end
                default: ;
            endcase
        end
        if (last)
        begin
            // the final pop can itself raise underflow, so read the flags after it
            res.value     = eval_pop();
            res.underflow = eval_underflow;
            res.overflow  = eval_overflow;
            res.div_zero  = eval_div_zero;
            expected_results.push_back(res);
            eval_depth     = 0;
            eval_underflow = 1'b0;
            eval_overflow  = 1'b0;
            eval_div_zero  = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what, input logic [pfx_pkg::DATA_W-1:0] got,
                                 input logic [pfx_pkg::DATA_W-1:0] want);
        mismatch_count++;
        $display("mismatch on %s: got %h, expected %h", what, got, want);
    endtask

    // ---------------------------------------------------------------
    // driver: offers queued characters, predicts on each transfer
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_ch_if.valid       <= 1'b0;
            sym_ch_if.symbol      <= '0;
            sym_ch_if.last_symbol <= 1'b0;
        end
        else
        begin
            if (sym_ch_if.valid && sym_ch_if.ready)
            begin
                evaluate_symbol(sym_ch_if.symbol, sym_ch_if.last_symbol);
            end
            // only move on once the current character has gone, or none is offered
            if (!sym_ch_if.valid || sym_ch_if.ready)
            begin
                if (pending_symbols.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    next_symbol            = pending_symbols.pop_front();
                    sym_ch_if.valid       <= 1'b1;
                    sym_ch_if.symbol      <= next_symbol.sym;
                    sym_ch_if.last_symbol <= next_symbol.last;
                end
                else
                begin
                    sym_ch_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stalls, plus the long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch_if.ready <= 1'b0;
            hold_seen       <= 0;
            hold_left       <= 0;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen       <= hold_seq;
            hold_left       <= HOLD_CYCLES;
            res_ch_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            res_ch_if.ready <= 1'b0;
        end
        else
        begin
            res_ch_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // monitor and watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch_if.valid && res_ch_if.ready)
            begin
                got_result.value     = res_ch_if.value;
                got_result.underflow = res_ch_if.underflow_seen;
                got_result.overflow  = res_ch_if.overflow_seen;
                got_result.div_zero  = res_ch_if.divide_by_zero_seen;
                if (expected_results.size() == 0)
                begin
                    note_mismatch("result with nothing owed", got_result.value, '0);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (got_result.value !== want_result.value)
                        note_mismatch("value", got_result.value, want_result.value);
                    if (got_result.underflow !== want_result.underflow)
                        note_mismatch("underflow_seen", got_result.underflow,
                                      want_result.underflow);
                    if (got_result.overflow !== want_result.overflow)
                        note_mismatch("overflow_seen", got_result.overflow,
                                      want_result.overflow);
                    if (got_result.div_zero !== want_result.div_zero)
                        note_mismatch("divide_by_zero_seen", got_result.div_zero,
                                      want_result.div_zero);
                end
            end
            // any transfer on either side counts as progress
            if ((sym_ch_if.valid && sym_ch_if.ready) || (res_ch_if.valid && res_ch_if.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("tb NOT OK");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic queue_symbol(input logic [pfx_pkg::SYM_W-1:0] sym, input logic last);
        symbol_item_t item;
        item.sym  = sym;
        item.last = last;
        pending_symbols.push_back(item);
    endtask

    function automatic logic [pfx_pkg::SYM_W-1:0] random_digit();
        // nines more often so that products grow and wrap
        if ($urandom_range(0, 3) == 0)
            return pfx_pkg::CHAR_NINE;
        return pfx_pkg::CHAR_ZERO + pfx_pkg::SYM_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [pfx_pkg::SYM_W-1:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return pfx_pkg::CHAR_PLUS;
            1:       return pfx_pkg::CHAR_MINUS;
            2:       return pfx_pkg::CHAR_STAR;
            default: return pfx_pkg::CHAR_SLASH;
        endcase
    endfunction

    // whole expressions until at least target characters are queued
    task automatic queue_random_items(input int target);
        int                        added;
        int                        kind;
        int                        n_left;
        int                        depth;
        int                        len;
        int                        n_ops;
        int                        i;
        logic [pfx_pkg::SYM_W-1:0] s;
        added = 0;
        while (added < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                // well-formed: never pop below two, close with one value left
                n_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
                                                     : $urandom_range(1, 8);
                depth  = 0;
                while (n_left > 0 || depth > 1)
                begin
                    if (depth < 2 || (n_left > 0 && $urandom_range(0, 1) == 1))
                    begin
                        s = random_digit();
                        n_left--;
                        depth++;
                    end
                    else
                    begin
                        s = random_operator();
                        depth--;
                    end
                    queue_symbol(s, !(n_left > 0 || depth > 1));
                    added++;
                end
            end
            else if (kind < 75)
            begin
                // run from just below to past the stack depth, then fold a few
                len   = $urandom_range(pfx_pkg::STACK_DEPTH - 2, pfx_pkg::STACK_DEPTH + 4);
                n_ops = $urandom_range(0, 4);
                for (i = 0; i < len; i++)
                    queue_symbol(random_digit(), (i == len - 1) && (n_ops == 0));
                for (i = 0; i < n_ops; i++)
                    queue_symbol(random_operator(), i == n_ops - 1);
                added += len + n_ops;
            end
            else if (kind < 90)
            begin
                // broken: digits, operators and stray bytes in any order
                len = $urandom_range(1, 10);
                for (i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 2))
                        0:       s = random_digit();
                        1:       s = random_operator();
                        default: s = pfx_pkg::SYM_W'($urandom_range(0, 255));
                    endcase
                    queue_symbol(s, i == len - 1);
                end
                added += len;
            end
            else
            begin
                // pure noise bytes
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                    queue_symbol(pfx_pkg::SYM_W'($urandom_range(0, 255)), i == len - 1);
                added += len;
            end
        end
    endtask

    task automatic wait_for_sender();
        while (pending_symbols.size() != 0 || sym_ch_if.valid)
            @(negedge clk);
    endtask

    task automatic wait_until_drained();
        wait_for_sender();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int i;
        wait (rst_n === 1'b1);
        @(negedge clk);

        // directed: digit extremes, each operator, the special cases
        queue_symbol(pfx_pkg::CHAR_ZERO, 1'b1);
        queue_symbol(pfx_pkg::CHAR_NINE, 1'b1);
        queue_symbol(pfx_pkg::CHAR_ZERO + 8'd3, 1'b0);
        queue_symbol(pfx_pkg::CHAR_ZERO + 8'd4, 1'b0);
        queue_symbol(pfx_pkg::CHAR_PLUS, 1'b1);
        queue_symbol(pfx_pkg::CHAR_NINE, 1'b0);
        queue_symbol(pfx_pkg::CHAR_ZERO + 8'd5, 1'b0);
        queue_symbol(pfx_pkg::CHAR_MINUS, 1'b1);
        queue_symbol(pfx_pkg::CHAR_ZERO + 8'd7, 1'b0);
        queue_symbol(pfx_pkg::CHAR_ZERO + 8'd8, 1'b0);
        queue_symbol(pfx_pkg::CHAR_STAR, 1'b1);
        queue_symbol(pfx_pkg::CHAR_NINE, 1'b0);
        queue_symbol(pfx_pkg::CHAR_ZERO + 8'd3, 1'b0);
        queue_symbol(pfx_pkg::CHAR_SLASH, 1'b1);
        // zero divisor
        queue_symbol(pfx_pkg::CHAR_ZERO + 8'd5, 1'b0);
        queue_symbol(pfx_pkg::CHAR_ZERO, 1'b0);
        queue_symbol(pfx_pkg::CHAR_SLASH, 1'b1);
        // most negative from an empty pop, then divided by minus one
        queue_symbol(pfx_pkg::CHAR_ZERO, 1'b0);
        queue_symbol(pfx_pkg::CHAR_PLUS, 1'b0);
        queue_symbol(pfx_pkg::CHAR_ZERO, 1'b0);
        queue_symbol(pfx_pkg::CHAR_ZERO + 8'd1, 1'b0);
        queue_symbol(pfx_pkg::CHAR_MINUS, 1'b0);
        queue_symbol(pfx_pkg::CHAR_SLASH, 1'b1);
        // non-operator bytes on an empty stack
        queue_symbol(8'h00, 1'b0);
        queue_symbol(8'hFF, 1'b1);
        wait_until_drained();

        // random phases with different idling on each side
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        queue_random_items(170);
        wait_for_sender();
        tx_idle_pct  = 72;
        rx_stall_pct = 0;
        queue_random_items(170);
        wait_for_sender();
        tx_idle_pct  = 0;
        rx_stall_pct = 72;
        queue_random_items(170);
        wait_for_sender();
        tx_idle_pct  = 18;
        rx_stall_pct = 18;
        queue_random_items(170);
        wait_for_sender();

        // receiver holds off while short expressions keep coming: input must stall
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_seq     = hold_seq + 1;
        for (i = 0; i < 24; i++)
            queue_symbol(random_digit(), 1'b1);
        wait_for_sender();

        // sender pauses until every owed result has arrived
        wait_until_drained();

        tx_idle_pct  = 18;
        rx_stall_pct = 18;
        queue_random_items(100);
        wait_until_drained();

        // let any character still being worked on show up as a stray result
        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            note_mismatch("results never delivered", expected_results.size(), '0);

        if (mismatch_count == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
